FILE: src/cl_pkg.sv
// Shared constants and types for the circular list block.
package cl_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_BITS  = 32;
    localparam int SLOT_BITS  = $clog2(DEPTH);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [WORD_BITS-1:0]  word_t;

    typedef enum logic [3:0] {
        CMD_APPEND = 4'd0,
        CMD_POP    = 4'd1,
        CMD_DELETE = 4'd2,
        CMD_NEXT   = 4'd3,
        CMD_PREV   = 4'd4,
        CMD_FIRST  = 4'd5,
        CMD_LAST   = 4'd6,
        CMD_READ   = 4'd7,
        CMD_WRITE  = 4'd8,
        CMD_SEARCH = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_LINK,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

FILE: src/cl_store.sv
// Element word and link memories, one synchronous read port each.
module cl_store
    import cl_pkg::*;
(
    input  logic  clk,
    input  slot_t rd_addr,
    output word_t rd_elem,
    output slot_t rd_next,
    output slot_t rd_prev,
    input  logic  we_elem,
    input  slot_t wa_elem,
    input  word_t wd_elem,
    input  logic  we_next,
    input  slot_t wa_next,
    input  slot_t wd_next,
    input  logic  we_prev,
    input  slot_t wa_prev,
    input  slot_t wd_prev
);

    word_t elem_mem [DEPTH];
    slot_t next_mem [DEPTH];
    slot_t prev_mem [DEPTH];

    // Write ports
    always_ff @(posedge clk)
    begin
        if (we_elem)
        begin
            elem_mem[wa_elem] <= wd_elem;
        end
        if (we_next)
        begin
            next_mem[wa_next] <= wd_next;
        end
        if (we_prev)
        begin
            prev_mem[wa_prev] <= wd_prev;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_elem <= elem_mem[rd_addr];
        rd_next <= next_mem[rd_addr];
        rd_prev <= prev_mem[rd_addr];
    end

endmodule

FILE: src/circular_list_with_cursor.sv
// Top level of the circular list with cursor.
//
// Commands enter on start/cmd/value while busy is low. Each item returns one
// result on done with error, read_value, count and cursor_valid; the strobe
// lasts one cycle and the receiver cannot hold it off.
// Element words and both link arrays sit in single-read-port memories with a
// registered read; every command first reads the cursor (or head) entry.
// Cursor moves, read, write, first, last and errors pass through the read and
// execute states to done; append, pop and delete add a link write state.
// Search walks one element per cycle through the read port, visiting at most
// DEPTH elements; busy drops the cycle after done.
// Free slots are a stack of slot indices; instead of a clearing pass after
// reset a fill mark hands out fresh slots in order from 0 until every slot
// has gone out once, then pops the stack; commands are taken from the first cycle.
// match_mask is written through cfg_valid/cfg_ready while no item is at work;
// cfg_ready is high whenever busy is low.
// Reset empties the list, invalidates the cursor and sets match_mask to ones.
module circular_list_with_cursor
    import cl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] value,
    output logic        done,
    output logic        error,
    output logic [31:0] read_value,
    output logic [6:0]  count,
    output logic        cursor_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;
    logic [3:0] cmd_reg;
    word_t  val_reg;
    word_t  mask_reg;
    slot_t  head_reg, head_next;
    slot_t  tail_reg, tail_next;
    slot_t  cur_reg, cur_next;
    logic   cok_reg, cok_next;
    count_t cnt_reg, cnt_next;
    count_t fresh_reg, fresh_next;
    count_t fcnt_reg, fcnt_next;
    slot_t  walk_reg, walk_next;
    count_t steps_reg, steps_next;
    slot_t  aux_reg, aux_next;
    slot_t  aux2_reg, aux2_next;
    logic   err_reg, err_next;
    word_t  rdv_reg, rdv_next;
    logic   done_reg;

    // Free stack: slots returned are pushed here, fresh slots come from fresh_reg
    slot_t  free_mem [DEPTH];
    logic   fpush;
    slot_t  fpush_slot;
    slot_t  ftop_reg;

    slot_t  rd_addr;
    word_t  rd_elem;
    slot_t  rd_next;
    slot_t  rd_prev;
    logic   we_elem, we_next, we_prev;
    slot_t  wa_elem, wa_next, wa_prev, wd_next, wd_prev;
    word_t  wd_elem;

    cl_store u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_elem (rd_elem),
        .rd_next (rd_next),
        .rd_prev (rd_prev),
        .we_elem (we_elem),
        .wa_elem (wa_elem),
        .wd_elem (wd_elem),
        .we_next (we_next),
        .wa_next (wa_next),
        .wd_next (wd_next),
        .we_prev (we_prev),
        .wa_prev (wa_prev),
        .wd_prev (wd_prev)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;

    // Push returned slots; read the top of the stack into a register every cycle
    always_ff @(posedge clk)
    begin
        if (fpush)
        begin
            free_mem[fcnt_reg[SLOT_BITS-1:0]] <= fpush_slot;
        end
        ftop_reg <= free_mem[fcnt_reg[SLOT_BITS-1:0] - SLOT_BITS'(1)];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mask_reg  <= '1;
            head_reg  <= '0;
            tail_reg  <= '0;
            cur_reg   <= '0;
            cok_reg   <= 1'b0;
            cnt_reg   <= '0;
            fresh_reg <= '0;
            fcnt_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cur_reg   <= cur_next;
            cok_reg   <= cok_next;
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            fcnt_reg  <= fcnt_next;
            done_reg  <= (state_next == ST_DONE);
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
            val_reg <= value;
        end
        walk_reg  <= walk_next;
        steps_reg <= steps_next;
        aux_reg   <= aux_next;
        aux2_reg  <= aux2_next;
        err_reg   <= err_next;
        rdv_reg   <= rdv_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        cok_next   = cok_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        fcnt_next  = fcnt_reg;
        walk_next  = walk_reg;
        steps_next = steps_reg;
        aux_next   = aux_reg;
        aux2_next  = aux2_reg;
        err_next   = err_reg;
        rdv_next   = rdv_reg;
        rd_addr    = cok_reg ? cur_reg : head_reg;
        we_elem = 1'b0; wa_elem = cur_reg; wd_elem = val_reg;
        we_next = 1'b0; wa_next = '0; wd_next = '0;
        we_prev = 1'b0; wa_prev = '0; wd_prev = '0;
        fpush = 1'b0; fpush_slot = cur_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Memory read of cursor/head entry issued this cycle
                if (cmd_reg == CMD_POP)
                begin
                    rd_addr = head_reg;
                end
                err_next   = 1'b0;
                rdv_next   = '0;
                walk_next  = cok_reg ? cur_reg : head_reg;
                steps_next = '0;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (cnt_reg == count_t'(DEPTH))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (fresh_reg != count_t'(DEPTH))
                            begin
                                aux_next   = fresh_reg[SLOT_BITS-1:0];
                                fresh_next = fresh_reg + count_t'(1);
                            end
                            else
                            begin
                                aux_next  = ftop_reg;
                                fcnt_next = fcnt_reg - count_t'(1);
                            end
                            state_next = ST_LINK;
                        end
                    end
                    CMD_POP, CMD_DELETE:
                    begin
                        if (cnt_reg == '0 || (cmd_reg == CMD_DELETE && !cok_reg))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            // Target slot: head for pop, cursor for delete
                            aux_next = (cmd_reg == CMD_POP) ? head_reg : cur_reg;
                            if (cmd_reg == CMD_DELETE || cur_reg == head_reg)
                            begin
                                cok_next = (cmd_reg == CMD_POP) ? 1'b0 : 1'b0;
                            end
                            if (cmd_reg == CMD_POP && cur_reg != head_reg)
                            begin
                                cok_next = cok_reg;
                            end
                            state_next = ST_LINK;
                        end
                    end
                    CMD_NEXT, CMD_PREV:
                    begin
                        if (cnt_reg == '0 || !cok_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = (cmd_reg == CMD_NEXT) ? rd_next : rd_prev;
                        end
                    end
                    CMD_FIRST, CMD_LAST:
                    begin
                        if (cnt_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = (cmd_reg == CMD_FIRST) ? head_reg : tail_reg;
                            cok_next = 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        if (!cok_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            rdv_next = rd_elem;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (!cok_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            we_elem = 1'b1;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (cnt_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
                // Keep the link pair of the target for the edit cycle
                aux2_next = rd_prev;
                if (cmd_reg == CMD_DELETE || cmd_reg == CMD_POP)
                begin
                    walk_next = rd_next;
                end
                if (cmd_reg == CMD_SEARCH)
                begin
                    // Read the start entry again so the walk tests it first
                    rd_addr = walk_reg;
                end
            end
            ST_WALK:
            begin
                // rd_* hold entry walk_reg; its successor is read in parallel
                rd_addr = rd_next;
                if ((rd_elem & mask_reg) == (val_reg & mask_reg))
                begin
                    cur_next   = walk_reg;
                    cok_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (rd_next == head_reg ||
                         steps_reg + count_t'(1) == cnt_reg)
                begin
                    cur_next   = rd_next;
                    cok_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    walk_next  = rd_next;
                    steps_next = steps_reg + count_t'(1);
                end
            end
            ST_LINK:
            begin
                state_next = ST_DONE;
                if (cmd_reg == CMD_APPEND)
                begin
                    we_elem = 1'b1;
                    wa_elem = aux_reg;
                    we_next = 1'b1; wa_next = aux_reg;
                    we_prev = 1'b1; wa_prev = aux_reg;
                    tail_next = aux_reg;
                    cnt_next  = cnt_reg + count_t'(1);
                    if (cnt_reg == '0)
                    begin
                        wd_next   = aux_reg;
                        wd_prev   = aux_reg;
                        head_next = aux_reg;
                    end
                    else
                    begin
                        // New node links; old tail and head fixed next cycle
                        wd_next    = head_reg;
                        wd_prev    = tail_reg;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    fpush      = 1'b1;
                    fpush_slot = aux_reg;
                    fcnt_next  = fcnt_reg + count_t'(1);
                    cnt_next   = cnt_reg - count_t'(1);
                    if (cnt_reg == count_t'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                        cok_next  = 1'b0;
                    end
                    else
                    begin
                        // Splice prev (aux2) and next (walk) around the target
                        we_next = 1'b1; wa_next = aux2_reg; wd_next = walk_reg;
                        we_prev = 1'b1; wa_prev = walk_reg; wd_prev = aux2_reg;
                        if (aux_reg == head_reg)
                        begin
                            head_next = walk_reg;
                        end
                        if (aux_reg == tail_reg)
                        begin
                            tail_next = aux2_reg;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Second half of a non-empty append: old tail and head point to new node
        if (state_reg == ST_DONE && cmd_reg == CMD_APPEND && !err_reg &&
            cnt_reg > count_t'(1))
        begin
            we_next = 1'b1; wa_next = aux2_reg; wd_next = aux_reg;
            we_prev = 1'b1; wa_prev = head_reg; wd_prev = aux_reg;
        end
        // Remember old tail for that second write
        if (state_reg == ST_LINK && cmd_reg == CMD_APPEND)
        begin
            aux2_next = tail_reg;
        end
    end

    // Result ports
    assign done         = done_reg;
    assign error        = err_reg;
    assign read_value   = rdv_reg;
    assign count        = cnt_reg;
    assign cursor_valid = cok_reg;

    // The cursor is only valid on a non-empty list
    assert property (@(posedge clk) disable iff (!rst_n) cok_reg |-> cnt_reg != '0)
        else $error("cursor valid on empty list");

    // Count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= count_t'(DEPTH))
        else $error("element count overflow");

    // Done strobe is a single cycle followed by ready
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg && !busy)
        else $error("done not followed by idle");

    // Count moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + count_t'(1) ||
        cnt_reg == $past(cnt_reg) - count_t'(1))
        else $error("count jumped");

endmodule

FILE: test/circular_list_with_cursor_tb.sv
// Self-checking testbench for the circular list with cursor.
module circular_list_with_cursor_tb
    import cl_pkg::*;
;

    // Holds a software copy of the list and the outcomes still awaited.
    class list_scoreboard;
        typedef struct packed {
            logic        error;
            logic [31:0] read_value;
            logic [6:0]  count;
            logic        cursor_valid;
        } outcome_t;

        word_t    words [DEPTH];
        slot_t    nxt [DEPTH];
        slot_t    prv [DEPTH];
        slot_t    stack [DEPTH];
        int       free_n;
        slot_t    head;
        slot_t    tail;
        slot_t    cur;
        bit       cur_ok;
        int       n_elem;
        word_t    mask;
        outcome_t awaited [$];
        int       errors;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                stack[i] = slot_t'(DEPTH - 1 - i);
                words[i] = '0;
                nxt[i] = '0;
                prv[i] = '0;
            end
            free_n = DEPTH;
            head = '0;
            tail = '0;
            cur = '0;
            cur_ok = 0;
            n_elem = 0;
            mask = '1;
            errors = 0;
        endfunction

        function void drop_head();
            slot_t old;
            old = head;
            if (cur_ok && cur == old)
                cur_ok = 0;
            if (n_elem == 1)
            begin
                n_elem = 0;
                cur_ok = 0;
                head = '0;
                tail = '0;
            end
            else
            begin
                head = nxt[old];
                prv[head] = tail;
                nxt[tail] = head;
                n_elem--;
            end
            if (free_n < DEPTH)
            begin
                stack[free_n] = old;
                free_n++;
            end
        endfunction

        // Apply one accepted command and note the outcome it must give.
        function void note_command(logic [3:0] c, word_t v);
            outcome_t o;
            bit       empty;
            bit       found;
            slot_t    s;
            slot_t    p;
            slot_t    q;
            int       steps;
            o = '0;
            empty = (n_elem == 0);
            case (c)
                CMD_APPEND:
                    if (free_n == 0 || n_elem >= DEPTH)
                        o.error = 1;
                    else
                    begin
                        free_n--;
                        s = stack[free_n];
                        words[s] = v;
                        if (empty)
                        begin
                            nxt[s] = s;
                            prv[s] = s;
                            head = s;
                        end
                        else
                        begin
                            nxt[tail] = s;
                            prv[s] = tail;
                            nxt[s] = head;
                            prv[head] = s;
                        end
                        tail = s;
                        n_elem++;
                    end
                CMD_POP:
                    if (empty)
                        o.error = 1;
                    else
                        drop_head();
                CMD_DELETE:
                    if (empty || !cur_ok)
                        o.error = 1;
                    else if (cur == head)
                    begin
                        drop_head();
                        cur_ok = 0;
                    end
                    else
                    begin
                        p = prv[cur];
                        q = nxt[cur];
                        if (cur == tail)
                            tail = p;
                        nxt[p] = q;
                        prv[q] = p;
                        if (free_n < DEPTH)
                        begin
                            stack[free_n] = cur;
                            free_n++;
                        end
                        cur_ok = 0;
                        n_elem--;
                    end
                CMD_NEXT, CMD_PREV:
                    if (empty || !cur_ok)
                        o.error = 1;
                    else
                        cur = (c == CMD_NEXT) ? nxt[cur] : prv[cur];
                CMD_FIRST, CMD_LAST:
                    if (empty)
                        o.error = 1;
                    else
                    begin
                        cur = (c == CMD_FIRST) ? head : tail;
                        cur_ok = 1;
                    end
                CMD_READ:
                    if (!cur_ok)
                        o.error = 1;
                    else
                        o.read_value = words[cur];
                CMD_WRITE:
                    if (!cur_ok)
                        o.error = 1;
                    else
                        words[cur] = v;
                CMD_SEARCH:
                    if (empty)
                        o.error = 1;
                    else
                    begin
                        s = cur_ok ? cur : head;
                        steps = 0;
                        found = 0;
                        while (steps < n_elem)
                        begin
                            if ((words[s] & mask) == (v & mask))
                            begin
                                found = 1;
                                break;
                            end
                            s = nxt[s];
                            steps++;
                            if (s == head)
                                break;
                        end
                        cur = s;
                        cur_ok = found;
                    end
                default:
                    o.error = 1;
            endcase
            o.count = 7'(n_elem);
            o.cursor_valid = cur_ok;
            awaited.push_back(o);
        endfunction

        // Compare one result with the oldest outcome awaited.
        function void check_result(logic e, logic [31:0] rv, logic [6:0] cnt, logic cv);
            outcome_t x;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result error=%0b read=%h count=%0d cv=%0b",
                         $time, e, rv, cnt, cv);
                errors++;
                return;
            end
            x = awaited.pop_front();
            if (e !== x.error)
            begin
                $display("%0t: error exp %0b act %0b", $time, x.error, e);
                errors++;
            end
            if (rv !== x.read_value)
            begin
                $display("%0t: read_value exp %h act %h", $time, x.read_value, rv);
                errors++;
            end
            if (cnt !== x.count)
            begin
                $display("%0t: count exp %0d act %0d", $time, x.count, cnt);
                errors++;
            end
            if (cv !== x.cursor_valid)
            begin
                $display("%0t: cursor_valid exp %0b act %0b", $time, x.cursor_valid, cv);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [3:0]  cmd = '0;
    logic [31:0] value = '0;
    logic        done;
    logic        error;
    logic [31:0] read_value;
    logic [6:0]  count;
    logic        cursor_valid;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    list_scoreboard board;
    int             idle_pct;
    int             cycles;

    circular_list_with_cursor u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .value(value), .done(done), .error(error), .read_value(read_value),
        .count(count), .cursor_valid(cursor_valid), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Check each result strobe and watch the cycle budget.
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && done)
            board.check_result(error, read_value, count, cursor_valid);
        if (cycles > 600000)
        begin
            $display("circular_list_with_cursor regression: fail");
            $finish;
        end
    end

    // Issue one command, with a random gap first, and wait for acceptance.
    task automatic issue(logic [3:0] c, logic [31:0] v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        start <= 1;
        cmd <= c;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(c, v);
        @(negedge clk);
        start <= 0;
    endtask

    // Wait for all outcomes, then a margin for the slowest search.
    task automatic drain();
        while (board.awaited.size() != 0)
            @(negedge clk);
        repeat (DEPTH + 8)
            @(negedge clk);
    endtask

    // Write the match mask while the block is idle.
    task automatic set_mask(logic [31:0] m);
        drain();
        cfg_valid <= 1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.mask = m;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return 32'hFFFF_FFF8 | $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // Weight commands toward growth, with a few unknown codes.
    function automatic logic [3:0] pick_cmd(int fill_bias);
        int r;
        r = $urandom_range(99);
        if (r < fill_bias) return CMD_APPEND;
        if (r < 97) return 4'($urandom_range(CMD_SEARCH));
        return 4'($urandom_range(15, 10));
    endfunction

    initial
    begin
        board = new();
        idle_pct = 0;
        cycles = 0;
        repeat (8)
            @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: empty-list errors, invalid cursor, unknown codes.
        issue(CMD_POP, 0);
        issue(CMD_DELETE, 0);
        issue(CMD_NEXT, 0);
        issue(CMD_PREV, 0);
        issue(CMD_FIRST, 0);
        issue(CMD_LAST, 0);
        issue(CMD_SEARCH, 0);
        issue(CMD_READ, 0);
        issue(CMD_WRITE, 0);
        issue(4'd15, 32'hFFFF_FFFF);
        // Single element: next and prev stay put.
        issue(CMD_APPEND, 32'hFFFF_FFFF);
        issue(CMD_FIRST, 0);
        issue(CMD_NEXT, 0);
        issue(CMD_PREV, 0);
        issue(CMD_READ, 0);
        issue(CMD_APPEND, 32'h0);
        issue(CMD_APPEND, 32'h5A5A_0001);
        issue(CMD_SEARCH, 32'h5A5A_0001);
        issue(CMD_WRITE, 32'h1234_5678);
        issue(CMD_SEARCH, 32'hDEAD_BEEF);
        issue(CMD_FIRST, 0);
        issue(CMD_POP, 0);
        issue(CMD_LAST, 0);
        issue(CMD_DELETE, 0);
        issue(CMD_POP, 0);
        // Fill to full and overflow once.
        for (int i = 0; i < DEPTH; i++)
            issue(CMD_APPEND, $urandom);
        issue(CMD_APPEND, 32'hAAAA_AAAA);
        issue(CMD_LAST, 0);
        issue(CMD_SEARCH, 32'h0);

        // Random phases through several masks and idle rates.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_mask(32'h0);
                1: set_mask(32'h0000_0007);
                2: set_mask(32'hFFFF_FFFF);
                3: set_mask($urandom);
                4: set_mask(32'h8000_0001);
                default: set_mask($urandom | 32'h7);
            endcase
            idle_pct = (ph % 4 == 1) ? 72 : (ph % 4 == 3) ? 19 : 0;
            for (int i = 0; i < 200; i++)
                issue(pick_cmd((ph % 2) ? 45 : 20), pick_word());
            // Hold off until every outcome has arrived.
            drain();
        end

        drain();
        if (board.errors == 0)
            $display("circular_list_with_cursor regression: pass");
        else
            $display("circular_list_with_cursor regression: fail");
        $finish;
    end
endmodule
